@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page table walker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/tlptw_pkg.sv @@
// ----------------------------------------------------------------------------
// tlptw_pkg
// Types and codes shared by the page table walker and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tlptw_pkg;

  typedef logic [63:0] va_t;
  typedef logic [39:0] pa_t;
  typedef logic [63:0] desc_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] FLT_REGION = 2'd0;
  localparam logic [1:0] FLT_L1     = 2'd1;
  localparam logic [1:0] FLT_L2     = 2'd2;
  localparam logic [1:0] FLT_L3     = 2'd3;
  localparam logic [1:0] FLT_NONE   = 2'd0;

  localparam logic [1:0] DESC_VALID = 2'b11;
  localparam int         DESC_SHIFT = 3;

  typedef struct packed {
    logic       kind;
    pa_t        read_addr;
    logic       fault;
    logic [1:0] fault_level;
    pa_t        phys_addr;
    desc_t      leaf_entry;
    va_t        next_virt_addr;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/three_level_page_table_walker_top.sv @@
// ----------------------------------------------------------------------------
// three_level_page_table_walker_top
// Three-level page table walker with a 16 KiB granule.
//
// The input channel carries start transfers (a virtual address) and read
// data transfers (a descriptor fetched from memory). The result channel
// carries descriptor read requests and a finish transfer with the physical
// address or the fault, the leaf descriptor and its address, and the next
// virtual address to probe. The walker issues one read request per level
// and waits for its data to come back on the input channel; memory latency
// lies outside the block.
// Each input transfer is handled in one pass of logic between the input
// ports and the result register: a result appears in the cycle after its
// input transfer, and one transfer can be taken every cycle while the
// input channel is not stalled. Transfers that give no result (a start
// while busy, data while idle) are still taken. When the receiver stalls,
// the result register holds and the input channel stalls until it is taken.
// Reset clears the walk state, the table base and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_table_walker_top #(
  parameter int L1_INDEX_BITS = 3,
  parameter int L2_INDEX_BITS = 11,
  parameter int L3_INDEX_BITS = 11,
  parameter int PAGE_BITS     = 14,
  parameter int PA_BITS       = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  tlptw_pkg::pa_t        cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_operation,
  input  tlptw_pkg::va_t        in_virt_addr,
  input  tlptw_pkg::desc_t      in_read_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_kind,
  output tlptw_pkg::pa_t        out_read_addr,
  output logic                  out_fault,
  output logic [1:0]            out_fault_level,
  output tlptw_pkg::pa_t        out_phys_addr,
  output tlptw_pkg::desc_t      out_leaf_entry,
  output tlptw_pkg::va_t        out_next_virt_addr
);

  import tlptw_pkg::*;

  localparam int SHIFT_L1    = L2_INDEX_BITS + L3_INDEX_BITS + PAGE_BITS;
  localparam int SHIFT_L2    = L3_INDEX_BITS + PAGE_BITS;
  localparam int REGION_BITS = L1_INDEX_BITS + SHIFT_L1;
  localparam int PA_W        = (PA_BITS < 40) ? PA_BITS : 40;

  localparam pa_t PA_MASK    = {40{1'b1}} >> (40 - PA_W);
  localparam pa_t OFF_MASK   = (40'd1 << PAGE_BITS) - 40'd1;
  localparam pa_t FRAME_MASK = PA_MASK & ~OFF_MASK;

  localparam va_t SPAN_L1     = 64'd1 << SHIFT_L1;
  localparam va_t SPAN_L2     = 64'd1 << SHIFT_L2;
  localparam va_t SPAN_L3     = 64'd1 << PAGE_BITS;
  localparam va_t REGION_BASE = {64{1'b1}} << REGION_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_L1, ST_L2, ST_L3} state_t;

  state_t state_r, state_nxt;
  pa_t    table_base_r;
  va_t    saved_vaddr_r, saved_vaddr_nxt;
  pa_t    leaf_addr_r, leaf_addr_nxt;
  logic   out_valid_r, res_vld;
  res_t   out_r, res;

  logic   take_in;
  logic   in_region;
  logic   desc_ok;
  pa_t    desc_frame;
  pa_t    l1_off, l2_off, l3_off;
  pa_t    req_addr;

  assign in_stall  = out_valid_r && out_stall;
  assign take_in   = in_valid && !in_stall;
  assign in_region = &in_virt_addr[63:REGION_BITS];
  assign desc_ok   = (in_read_data[1:0] & DESC_VALID) == DESC_VALID;
  assign desc_frame = in_read_data[39:0] & FRAME_MASK;

  assign l1_off = 40'(in_virt_addr[SHIFT_L1 +: L1_INDEX_BITS]) << DESC_SHIFT;
  assign l2_off = 40'(saved_vaddr_r[SHIFT_L2 +: L2_INDEX_BITS]) << DESC_SHIFT;
  assign l3_off = 40'(saved_vaddr_r[PAGE_BITS +: L3_INDEX_BITS]) << DESC_SHIFT;

  always_comb begin
    state_nxt       = state_r;
    saved_vaddr_nxt = saved_vaddr_r;
    leaf_addr_nxt   = leaf_addr_r;
    res_vld         = 1'b0;
    res             = '0;
    req_addr        = '0;
    if (take_in) begin
      if (in_operation == OP_START) begin
        if (state_r == ST_IDLE) begin
          res_vld = 1'b1;
          if (!in_region) begin
            res.kind           = KIND_DONE;
            res.fault          = 1'b1;
            res.fault_level    = FLT_REGION;
            res.next_virt_addr = REGION_BASE;
          end else begin
            saved_vaddr_nxt = in_virt_addr;
            state_nxt       = ST_L1;
            res.kind        = KIND_REQ;
            res.read_addr   = (table_base_r + l1_off) & PA_MASK;
          end
        end
      end else begin
        unique case (state_r)
          ST_IDLE: begin
          end
          ST_L1: begin
            res_vld = 1'b1;
            if (!desc_ok) begin
              state_nxt          = ST_IDLE;
              res.kind           = KIND_DONE;
              res.fault          = 1'b1;
              res.fault_level    = FLT_L1;
              res.next_virt_addr = (saved_vaddr_r & ~(SPAN_L1 - 64'd1)) + SPAN_L1;
            end else begin
              state_nxt     = ST_L2;
              res.kind      = KIND_REQ;
              res.read_addr = (desc_frame + l2_off) & PA_MASK;
            end
          end
          ST_L2: begin
            res_vld = 1'b1;
            if (!desc_ok) begin
              state_nxt          = ST_IDLE;
              res.kind           = KIND_DONE;
              res.fault          = 1'b1;
              res.fault_level    = FLT_L2;
              res.next_virt_addr = (saved_vaddr_r & ~(SPAN_L2 - 64'd1)) + SPAN_L2;
            end else begin
              req_addr      = (desc_frame + l3_off) & PA_MASK;
              state_nxt     = ST_L3;
              leaf_addr_nxt = req_addr;
              res.kind      = KIND_REQ;
              res.read_addr = req_addr;
            end
          end
          ST_L3: begin
            res_vld            = 1'b1;
            state_nxt          = ST_IDLE;
            res.kind           = KIND_DONE;
            res.read_addr      = leaf_addr_r;
            res.leaf_entry     = in_read_data;
            res.next_virt_addr = (saved_vaddr_r & ~(SPAN_L3 - 64'd1)) + SPAN_L3;
            if (!desc_ok) begin
              res.fault       = 1'b1;
              res.fault_level = FLT_L3;
            end else begin
              res.fault_level = FLT_NONE;
              res.phys_addr   = desc_frame | (saved_vaddr_r[39:0] & OFF_MASK);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      table_base_r  <= '0;
      saved_vaddr_r <= '0;
      leaf_addr_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      saved_vaddr_r <= saved_vaddr_nxt;
      leaf_addr_r   <= leaf_addr_nxt;
      if (cfg_wr_en) begin
        table_base_r <= cfg_wr_data;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_read_addr      = out_r.read_addr;
  assign out_fault          = out_r.fault;
  assign out_fault_level    = out_r.fault_level;
  assign out_phys_addr      = out_r.phys_addr;
  assign out_leaf_entry     = out_r.leaf_entry;
  assign out_next_virt_addr = out_r.next_virt_addr;

endmodule

`default_nettype wire

@@ rtl/tlptw_checker.sv @@
// ----------------------------------------------------------------------------
// tlptw_checker
// Port-level checks on the page table walker, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlptw_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_kind,
  input tlptw_pkg::pa_t        out_read_addr,
  input wire logic             out_fault,
  input wire logic [1:0]       out_fault_level,
  input tlptw_pkg::pa_t        out_phys_addr,
  input tlptw_pkg::desc_t      out_leaf_entry,
  input tlptw_pkg::va_t        out_next_virt_addr
);

  import tlptw_pkg::*;

  // A stalled result transfer holds its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_read_addr) && $stable(out_next_virt_addr))

  // The input side is only stalled while a result waits.
  `ASSERT_ALWAYS(a_stall_src, clk, rst_n, in_stall |-> (out_valid && out_stall))

  // A read request carries nothing but its address.
  `ASSERT_ALWAYS(a_req_clean, clk, rst_n, (out_valid && out_kind == KIND_REQ) |-> (!out_fault && out_fault_level == FLT_NONE && out_phys_addr == '0 && out_leaf_entry == '0 && out_next_virt_addr == '0))

  // A walk that stopped before the leaf shows no leaf and no physical address.
  `ASSERT_ALWAYS(a_early_fault, clk, rst_n, (out_valid && out_kind == KIND_DONE && out_fault && out_fault_level != FLT_L3) |-> (out_read_addr == '0 && out_leaf_entry == '0 && out_phys_addr == '0))

  // A successful finish reports no fault level.
  `ASSERT_ALWAYS(a_ok_level, clk, rst_n, (out_valid && out_kind == KIND_DONE && !out_fault) |-> (out_fault_level == FLT_NONE))

endmodule

bind three_level_page_table_walker_top tlptw_checker u_tlptw_checker (.*);

`default_nettype wire
